/* rtl/geo_air_sample_packet_packer_top_macros.svh */
// Assertion macros used by the packer top level.
`ifndef GEO_AIR_SAMPLE_PACKET_PACKER_TOP_MACROS_SVH
`define GEO_AIR_SAMPLE_PACKET_PACKER_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, held off during reset.
`define GASP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("packer assertion failed");

// Next-cycle implication, checked on clk, held off during reset.
`define GASP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("packer assertion failed");

`endif

/* rtl/gasp_pkg.sv */
// Package: constants and types of the geo air-sample packet packer.
package gasp_pkg;

	localparam int unsigned SAMPLES_PER_PACKET = 8;
	localparam int unsigned POS_W = (SAMPLES_PER_PACKET > 1) ? $clog2(SAMPLES_PER_PACKET) : 1;
	localparam int unsigned MAX_BYTES = 9;
	localparam int unsigned FIRST_BITS = 76;
	localparam int unsigned BODY_BITS = 42;
	localparam int unsigned WORD_W = 96;
	localparam logic [31:0] COORD_OFFSET = 32'h5A00_0000; // 180.0 in 9.23

	typedef struct packed {
		logic [9:0]  pm25;
		logic [9:0]  pm10;
		logic [31:0] lon;
		logic [31:0] lat;
	} sample_t;

endpackage

/* rtl/gasp_convert.sv */
// Float-to-fixed conversion of one sample: coordinates to 9.23, readings to 10 bits.
module gasp_convert (
	input  logic [31:0]      latitude_bits,
	input  logic [31:0]      longitude_bits,
	input  logic [31:0]      pm10_bits,
	input  logic [31:0]      pm25_bits,
	output gasp_pkg::sample_t sample
);

	localparam logic [31:0] COORD_OFFSET_W = gasp_pkg::COORD_OFFSET;

	// floor of value*2^23 + offset, saturating; negatives use the ceiling of |value|
	function automatic logic [31:0] coord_fix(input logic [31:0] f);
		logic [7:0]  e;
		logic [23:0] m;
		logic [40:0] lo;
		logic [40:0] hi;
		logic [47:0] x;
		logic [6:0]  r;
		logic [3:0]  sh;
		logic [41:0] t;
		logic [31:0] res;
		e = f[30:23];
		m = (e != 8'd0) ? {1'b1, f[22:0]} : {1'b0, f[22:0]};
		sh = 4'(e - 8'd127);
		r = (e == 8'd0) ? 7'd126 : 7'(8'd127 - e);
		x = {m, 24'd0} >> r[4:0];
		if (e > 8'd136) begin
			lo = 41'd1 << 40;
			hi = lo;
		end else if (e >= 8'd127) begin
			lo = {17'd0, m} << sh;
			hi = lo;
		end else if (r >= 7'd24) begin
			lo = '0;
			hi = {40'd0, (m != 24'd0)};
		end else begin
			lo = {17'd0, x[47:24]};
			hi = lo + {40'd0, (x[23:0] != 24'd0)};
		end
		t = {10'd0, COORD_OFFSET_W} + {1'b0, lo};
		if (e == 8'hFF) begin
			res = (f[22:0] != 23'd0 || f[31]) ? 32'd0 : 32'hFFFF_FFFF;
		end else if (!f[31]) begin
			res = (t > 42'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
		end else begin
			res = (hi > {9'd0, COORD_OFFSET_W}) ? 32'd0 : (COORD_OFFSET_W - hi[31:0]);
		end
		return res;
	endfunction

	// truncate toward zero, keep the low 10 bits; negatives, infinities and NaNs give zero
	function automatic logic [9:0] reading_fix(input logic [31:0] f);
		logic [7:0]  e;
		logic [6:0]  s;
		logic [23:0] m;
		logic [32:0] up;
		logic [9:0]  res;
		e = f[30:23];
		s = 7'(e - 8'd127);
		m = {1'b1, f[22:0]};
		up = {9'd0, m} << 4'(s - 7'd23);
		if (f[31] || e == 8'hFF || e < 8'd127) begin
			res = '0;
		end else if (s <= 7'd23) begin
			res = 10'(m >> 5'(7'd23 - s));
		end else if (s >= 7'd33) begin
			res = '0;
		end else begin
			res = up[9:0];
		end
		return res;
	endfunction

	assign sample.lat  = coord_fix(latitude_bits);
	assign sample.lon  = coord_fix(longitude_bits);
	assign sample.pm10 = reading_fix(pm10_bits);
	assign sample.pm25 = reading_fix(pm25_bits);

endmodule

/* rtl/geo_air_sample_packet_packer_top.sv */
// Top level: geo air-sample packet packer, sample stream in, packed byte stream out.
//
// Input channel s_axis: one beat per sample (lat, lon, PM10, PM2.5 float bit patterns).
// Output channel m_axis: the packet as bytes, MSB first; tlast on the final byte,
// 47 bytes per packet of eight samples.
// A sample sits in an input register, then in one pass is converted and merged with
// the pending bits of the previous sample into a byte buffer (up to 9 bytes).
// The buffer drains one byte per cycle while the receiver accepts; the first byte of a
// sample shows once the sample has passed the input register and the byte buffer.
// A sample yields 9 bytes if it is the first of a packet, 5 to 6 bytes otherwise.
// The next sample is taken into the input register while the buffer still drains,
// and moves into the buffer in the cycle its last byte is taken.
// When the receiver stalls, the buffer holds and the input register fills, then
// s_axis_tready drops. Reset clears the packet position, the pending bits and
// all valid flags; the block starts a fresh packet.
module geo_air_sample_packet_packer_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] latitude_bits, [63:32] longitude_bits, [95:64] pm10_bits, [127:96] pm25_bits
	input  logic [127:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [7:0] packet_byte
	output logic [7:0]   m_axis_tdata,
	output logic         m_axis_tlast
);

	localparam int unsigned POS_W = gasp_pkg::POS_W;
	localparam int unsigned WORD_W = gasp_pkg::WORD_W;
	localparam int unsigned BUF_W = 8 * gasp_pkg::MAX_BYTES;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(gasp_pkg::SAMPLES_PER_PACKET - 1);
	localparam logic [3:0] MAX_BYTES_C = 4'(gasp_pkg::MAX_BYTES);

	logic               valid_s1;
	logic [127:0]       data_s1;
	logic [POS_W-1:0]   pos_q;
	logic [6:0]         left_bits_q;
	logic [2:0]         left_cnt_q;
	logic [BUF_W-1:0]   buf_q;
	logic [3:0]         buf_cnt_q;
	logic               buf_last_q;

	gasp_pkg::sample_t  smp;
	logic               load;
	logic               first;
	logic               last;
	logic [WORD_W-1:0]  ext;
	logic [WORD_W-1:0]  pay;
	logic [WORD_W-1:0]  word;
	logic [WORD_W-1:0]  rest;
	logic [6:0]         nbits;
	logic [3:0]         nfull;
	logic [3:0]         nbytes;
	logic [6:0]         left_next;

	gasp_convert u_convert (
		.latitude_bits (data_s1[31:0]),
		.longitude_bits(data_s1[63:32]),
		.pm10_bits     (data_s1[95:64]),
		.pm25_bits     (data_s1[127:96]),
		.sample        (smp)
	);

	assign load = valid_s1 && (buf_cnt_q == 4'd0 || (buf_cnt_q == 4'd1 && m_axis_tready));
	assign s_axis_tready = !valid_s1 || load;

	assign first = (pos_q == '0);
	assign last  = (pos_q == POS_LAST);

	always_comb begin
		// pending bits go on top, the sample's bits follow them
		ext = {left_bits_q, (WORD_W - 7)'(0)} << (3'd7 - left_cnt_q);
		if (first) begin
			pay = {smp.lat[31:15], smp.lon[31:15], smp.lat[14:4], smp.lon[14:4],
				smp.pm10, smp.pm25, (WORD_W - gasp_pkg::FIRST_BITS)'(0)};
			nbits = 7'(gasp_pkg::FIRST_BITS);
		end else begin
			pay = {smp.lat[14:4], smp.lon[14:4], smp.pm10, smp.pm25,
				(WORD_W - gasp_pkg::BODY_BITS)'(0)};
			nbits = 7'(gasp_pkg::BODY_BITS) + {4'd0, left_cnt_q};
		end
		word = ext | (pay >> left_cnt_q);
		nfull = nbits[6:3];
		nbytes = (last && nbits[2:0] != 3'd0) ? nfull + 4'd1 : nfull;
		if (nbytes > MAX_BYTES_C) begin
			nbytes = MAX_BYTES_C;
		end
		rest = word << {nfull, 3'b000};
		left_next = rest[WORD_W-1 -: 7] >> (3'd7 - nbits[2:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			left_bits_q <= '0;
			left_cnt_q  <= '0;
			buf_cnt_q   <= '0;
			buf_last_q  <= 1'b0;
		end else if (load) begin
			pos_q       <= last ? '0 : pos_q + POS_W'(1);
			left_bits_q <= last ? 7'd0 : left_next;
			left_cnt_q  <= last ? 3'd0 : nbits[2:0];
			buf_cnt_q   <= nbytes;
			buf_last_q  <= last;
		end else if (m_axis_tvalid && m_axis_tready) begin
			buf_cnt_q <= buf_cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= word[WORD_W-1 -: BUF_W];
		end else if (m_axis_tvalid && m_axis_tready) begin
			buf_q <= {buf_q[BUF_W-9:0], 8'd0};
		end
	end

	assign m_axis_tvalid = (buf_cnt_q != 4'd0);
	assign m_axis_tdata  = buf_q[BUF_W-1 -: 8];
	assign m_axis_tlast  = buf_last_q && (buf_cnt_q == 4'd1);

`include "geo_air_sample_packet_packer_top_macros.svh"

	`GASP_ASSERT_NOW(a_buf_bound, 1'b1, buf_cnt_q <= MAX_BYTES_C)
	`GASP_ASSERT_NEXT(a_load_fills, load, buf_cnt_q != 4'd0)
	`GASP_ASSERT_NOW(a_packet_start_clean, load && first, left_cnt_q == 3'd0)
	`GASP_ASSERT_NOW(a_pending_mid_packet, left_cnt_q != 3'd0, pos_q != '0)

endmodule
